// File: src/ccw_pkg.sv
// ccw_pkg: shared types and constants for the coin change way counter
// no dependencies; imported by every module of the block but ccw_ram
package ccw_pkg;

  localparam int AMOUNT_W   = 12;
  localparam int COIN_W     = 12;
  localparam int KINDS_W    = 3;
  localparam int COUNT_W    = 64;
  localparam int COIN_REGS  = 5;
  localparam int MAX_KINDS  = 5;
  localparam int KIND_LIMIT = (MAX_KINDS < COIN_REGS) ? MAX_KINDS : COIN_REGS;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COIN_ONE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COIN_TWO     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COIN_THREE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COIN_FOUR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COIN_FIVE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KINDS_IN_USE = 3'd5;

  // reset values of the coin registers
  localparam logic [COIN_W-1:0] COIN_RESET [COIN_REGS] = '{
    12'd1, 12'd5, 12'd10, 12'd25, 12'd50
  };
  localparam logic [KINDS_W-1:0] KINDS_RESET = 3'd5;

  // one table entry: way count plus saturation mark
  typedef struct packed {
    logic               mark;
    logic [COUNT_W-1:0] count;
  } entry_t;

endpackage

// File: src/ccw_ram.sv
// ccw_ram: generic memory, one write port and two registered read ports
// no dependencies
module ccw_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, and read old contents on both ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: src/ccw_sat_add.sv
// ccw_sat_add: shared saturating adder for two table entries
// depends on ccw_pkg
module ccw_sat_add (
  input  ccw_pkg::entry_t here,
  input  ccw_pkg::entry_t below,
  output ccw_pkg::entry_t sum
);
  import ccw_pkg::*;

  logic [COUNT_W:0] total;
  logic             carry;

  // 65-bit add, clamp to all ones on carry out
  always_comb begin
    total     = {1'b0, here.count} + {1'b0, below.count};
    carry     = total[COUNT_W];
    sum.count = carry ? {COUNT_W{1'b1}} : total[COUNT_W-1:0];
    sum.mark  = here.mark | below.mark | carry;
  end

endmodule

// File: src/coin_change_way_counter_core.sv
// An amount beyond the table answers in the cycle after start. Otherwise the
// table is cleared, each coin kind in use, capped at five, is swept, and the
// result is read in S_FETCH and S_WAIT before done. The table clear writes one
// entry a cycle and each coin pass moves one entry a cycle through the shared
// adder. The next word is taken in the done cycle, never while busy; the
// receiver cannot stall. Sync reset restores coin registers.
module coin_change_way_counter_core #(
  parameter int MAX_AMOUNT = 4095
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [ccw_pkg::AMOUNT_W-1:0]     amount,
  output logic                             done,
  output logic [ccw_pkg::COUNT_W-1:0]      way_count,
  output logic                             overflow,
  input  logic                             cfg_we,
  input  logic [ccw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ccw_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ccw_pkg::*;

  localparam int DEPTH = MAX_AMOUNT + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (AW > AMOUNT_W) ? AW : AMOUNT_W;
  localparam int EW    = $bits(entry_t);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLEAR = 6'b000010,
    S_KIND  = 6'b000100,
    S_SWEEP = 6'b001000,
    S_FETCH = 6'b010000,
    S_WAIT  = 6'b100000
  } state_t;

  state_t             state;
  logic [COIN_W-1:0]  coin [COIN_REGS];
  logic [KINDS_W-1:0] kinds_in_use;
  logic [KINDS_W-1:0] kinds_eff;
  logic [KINDS_W-1:0] kind;
  logic [AW-1:0]      amt;
  logic [AW-1:0]      cnt;
  logic [AW-1:0]      coin_q;
  logic [CW-1:0]      amount_w;
  logic [CW-1:0]      amt_w;
  logic [CW-1:0]      coin_w;
  logic [COIN_W-1:0]  coin_sel;
  logic               out_of_range;
  logic               skip;

  logic               p_valid;
  logic [AW-1:0]      p_addr;
  logic               fwd_here;
  logic               fwd_below;
  entry_t             fwd_data;

  logic               we;
  logic [AW-1:0]      waddr;
  entry_t             wdata;
  logic [AW-1:0]      raddr_a;
  logic [AW-1:0]      raddr_b;
  logic [EW-1:0]      rdata_a;
  logic [EW-1:0]      rdata_b;
  entry_t             here_e;
  entry_t             below_e;
  entry_t             sum_e;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COIN_REGS; i++) begin
        coin[i] <= COIN_RESET[i];
      end
      kinds_in_use <= KINDS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COIN_ONE, REG_COIN_TWO, REG_COIN_THREE, REG_COIN_FOUR,
        REG_COIN_FIVE: begin
          coin[cfg_index] <= cfg_data[COIN_W-1:0];
        end
        REG_KINDS_IN_USE: begin
          kinds_in_use <= cfg_data[KINDS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // kind clamp, coin select and range checks
  always_comb begin
    kinds_eff    = (kinds_in_use > KINDS_W'(KIND_LIMIT)) ? KINDS_W'(KIND_LIMIT)
                                                         : kinds_in_use;
    coin_sel     = coin[kind];
    coin_w       = CW'(coin_sel);
    amt_w        = CW'(amt);
    amount_w     = CW'(amount);
    out_of_range = amount_w > CW'(MAX_AMOUNT);
    skip         = (coin_sel == '0) || (coin_w > amt_w);
  end

  // read addresses: current entry and the one a coin below
  always_comb begin
    raddr_a = (state == S_FETCH) ? amt : cnt;
    raddr_b = cnt - coin_q;
  end

  // operand select with bypass of a write landing on the read edge
  always_comb begin
    here_e  = fwd_here  ? fwd_data : entry_t'(rdata_a);
    below_e = fwd_below ? fwd_data : entry_t'(rdata_b);
  end

  ccw_sat_add u_add (
    .here  (here_e),
    .below (below_e),
    .sum   (sum_e)
  );

  // write port: clear sweep or update pipeline
  always_comb begin
    if (state == S_CLEAR) begin
      we          = 1'b1;
      waddr       = cnt;
      wdata.mark  = 1'b0;
      wdata.count = (cnt == '0) ? COUNT_W'(1) : '0;
    end else begin
      we    = p_valid;
      waddr = p_addr;
      wdata = sum_e;
    end
  end

  ccw_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // bypass tracking
  always_ff @(posedge clk) begin
    p_addr    <= cnt;
    fwd_here  <= p_valid && (p_addr == raddr_a);
    fwd_below <= p_valid && (p_addr == raddr_b);
    fwd_data  <= sum_e;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      p_valid <= 1'b0;
      kind    <= '0;
      cnt     <= '0;
    end else begin
      done    <= 1'b0;
      p_valid <= (state == S_SWEEP);
      case (state)
        S_IDLE: begin
          if (start) begin
            if (out_of_range) begin
              done <= 1'b1;
            end else begin
              cnt   <= '0;
              kind  <= '0;
              state <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          if (cnt == amt) begin
            state <= S_KIND;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_KIND: begin
          if (kind == kinds_eff) begin
            state <= S_FETCH;
          end else if (skip) begin
            kind <= kind + 1'b1;
          end else begin
            cnt   <= coin_w[AW-1:0];
            state <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (cnt == amt) begin
            kind  <= kind + 1'b1;
            state <= S_KIND;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FETCH: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request and coin payload registers
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start) begin
      amt       <= amount_w[AW-1:0];
      way_count <= {COUNT_W{1'b1}};
      overflow  <= 1'b1;
    end
    if ((state == S_KIND) && (kind != kinds_eff) && !skip) begin
      coin_q <= coin_w[AW-1:0];
    end
    if (state == S_WAIT) begin
      way_count <= here_e.count;
      overflow  <= here_e.mark;
    end
  end

  assign busy = (state != S_IDLE);

`ifndef SYNTHESIS
  // an accepted word leads to work or to an immediate answer
  a_start_takes: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted word produced neither busy nor done");

  // the result strobe only comes with the sequencer back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // update pipeline never overlaps the clear sweep
  a_no_clear_clash: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !p_valid)
    else $error("table write clash during clear");

  // the lower read address never wraps below zero
  a_below_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> (cnt >= coin_q))
    else $error("lower entry address wrapped");

  // a saturated result carries an all-ones count
  a_sat_ones: assert property (@(posedge clk) disable iff (rst)
    (done && overflow) |-> (&way_count))
    else $error("overflow without saturated count");
`endif

endmodule

// File: tb/sv/coin_change_way_counter_core_tb.sv
// coin_change_way_counter_core_tb: self-checking bench for the coin change way counter
// depends on ccw_pkg and coin_change_way_counter_core; random values from $urandom
`timescale 1ns / 1ps

module coin_change_way_counter_core_tb;
  import ccw_pkg::*;

  localparam int TABLE_TOP = 4095;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_PRINTS = 40;
  // register indexes past the last one; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum logic {JOB_AMOUNT, JOB_REG_WRITE} job_kind_t;

  typedef struct {
    job_kind_t               kind;
    logic [AMOUNT_W-1:0]     amt;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [CFG_DATA_W-1:0]   reg_data;
    int unsigned             gap_pct;
  } coin_job_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [AMOUNT_W-1:0]     amount = '0;
  logic                    done;
  logic [COUNT_W-1:0]      way_count;
  logic                    overflow;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  coin_job_t   job_q[$];
  entry_t      ways_due_q[$];

  // predictor copy of the configuration and the way-count table
  logic [COIN_W-1:0]   coin_reg [COIN_REGS];
  logic [KINDS_W-1:0]  kinds_reg;
  logic [COUNT_W-1:0]  way_tbl [0:TABLE_TOP];
  logic                sat_tbl [0:TABLE_TOP];

  int unsigned  cur_gap = 0;
  longint       cycle_n = 0;
  longint       cycle_limit = 20000;
  int unsigned  fail_n = 0;
  int unsigned  words_seen = 0;
  int unsigned  regs_written = 0;
  int unsigned  big_amounts = 0;

  coin_change_way_counter_core #(
    .MAX_AMOUNT(TABLE_TOP)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .amount(amount),
    .done(done),
    .way_count(way_count),
    .overflow(overflow),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // bounded dynamic program over amounts 0..amt, saturating counts
  function automatic entry_t count_ways(input logic [AMOUNT_W-1:0] amt);
    int unsigned kinds;
    int unsigned coin;
    int unsigned a;
    logic [COUNT_W:0] sum;
    logic mark;
    entry_t res;
    if (amt > TABLE_TOP) begin
      res.count = '1;
      res.mark = 1'b1;
      return res;
    end
    kinds = kinds_reg;
    if (kinds > KIND_LIMIT) kinds = KIND_LIMIT;
    for (a = 0; a <= amt; a++) begin
      way_tbl[a] = '0;
      sat_tbl[a] = 1'b0;
    end
    way_tbl[0] = 1;
    for (int k = 0; k < kinds; k++) begin
      coin = coin_reg[k];
      // zero coins are skipped, coins above the amount add nothing
      if (coin == 0 || coin > amt) continue;
      for (a = coin; a <= amt; a++) begin
        sum = {1'b0, way_tbl[a]} + {1'b0, way_tbl[a - coin]};
        mark = sat_tbl[a] | sat_tbl[a - coin];
        if (sum[COUNT_W]) begin
          sum = '1;
          mark = 1'b1;
        end
        way_tbl[a] = sum[COUNT_W-1:0];
        sat_tbl[a] = mark;
      end
    end
    res.count = way_tbl[amt];
    res.mark = sat_tbl[amt];
    return res;
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    if (idx <= REG_COIN_FIVE) coin_reg[idx] = data[COIN_W-1:0];
    else if (idx == REG_KINDS_IN_USE) kinds_reg = data[KINDS_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    fail_n++;
    if (fail_n <= MAX_PRINTS) $display("MISMATCH cycle %0d: %s", cycle_n, msg);
  endtask

  // stimulus queueing; each job adds its worst-case cycles to the run limit
  task automatic queue_amount(input int unsigned amt);
    coin_job_t j;
    j.kind = JOB_AMOUNT;
    j.amt = amt[AMOUNT_W-1:0];
    j.reg_idx = '0;
    j.reg_data = '0;
    j.gap_pct = cur_gap;
    job_q.push_back(j);
    cycle_limit += 4 * (6 * (amt + 1) + 10 + 200);
    if (amt > 511) big_amounts++;
  endtask

  task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    coin_job_t j;
    j.kind = JOB_REG_WRITE;
    j.amt = '0;
    j.reg_idx = idx;
    j.reg_data = data[CFG_DATA_W-1:0];
    j.gap_pct = cur_gap;
    job_q.push_back(j);
    cycle_limit += 4 * 200;
  endtask

  // fresh coin values and kind count, extremes included
  task automatic randomize_regs();
    int unsigned r;
    int unsigned val;
    for (int i = 0; i < COIN_REGS; i++) begin
      r = $urandom_range(9);
      if (r == 0) val = 0;
      else if (r == 1) val = 4095;
      else if (r < 7) val = $urandom_range(1, 12);
      else val = $urandom_range(1, 200);
      queue_reg(REG_COIN_ONE + CFG_IDX_W'(i), val);
    end
    r = $urandom_range(9);
    if (r == 0) val = 0;
    else if (r == 1) val = $urandom_range(6, 7);
    else val = $urandom_range(1, 5);
    queue_reg(REG_KINDS_IN_USE, val);
  endtask

  // mostly small amounts keep the run short; a few reach the full table
  task automatic random_phase(input int unsigned gap, input int unsigned n_items);
    int unsigned r;
    cur_gap = gap;
    randomize_regs();
    for (int i = 0; i < n_items; i++) begin
      if (i % 12 == 11) randomize_regs();
      r = $urandom_range(99);
      if (r < 80) queue_amount($urandom_range(0, 63));
      else if (r < 96) queue_amount($urandom_range(64, 511));
      else queue_amount($urandom_range(512, 4095));
    end
  endtask

  // driver: one word in flight on start, register writes only when idle
  always @(posedge clk) begin : drive_proc
    logic nxt_start;
    logic nxt_we;
    if (rst) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      nxt_start = start;
      nxt_we = 1'b0;
      if (cfg_we) begin
        apply_reg_write(cfg_index, cfg_data);
        regs_written++;
      end
      if (start && !busy) begin
        ways_due_q.push_back(count_ways(amount));
        nxt_start = 1'b0;
      end
      if (!nxt_start && job_q.size() > 0 && $urandom_range(99) >= job_q[0].gap_pct) begin
        if (job_q[0].kind == JOB_REG_WRITE) begin
          // done low keeps the due queue out of reach of the checker this edge
          if (!start && !busy && !done && ways_due_q.size() == 0) begin
            cfg_index <= job_q[0].reg_idx;
            cfg_data <= job_q[0].reg_data;
            nxt_we = 1'b1;
            void'(job_q.pop_front());
          end
        end else begin
          amount <= job_q[0].amt;
          nxt_start = 1'b1;
          void'(job_q.pop_front());
        end
      end
      start <= nxt_start;
      cfg_we <= nxt_we;
    end
  end

  // checker: every strobed word against the oldest predicted count
  always @(posedge clk) begin : check_proc
    entry_t want;
    if (!rst && done) begin
      if (ways_due_q.size() == 0) begin
        report_mismatch($sformatf("word with nothing due: count %0d overflow %0b",
                                  way_count, overflow));
      end else begin
        want = ways_due_q.pop_front();
        words_seen++;
        if (way_count !== want.count)
          report_mismatch($sformatf("way_count %0d, predicted %0d", way_count, want.count));
        if (overflow !== want.mark)
          report_mismatch($sformatf("overflow %0b, predicted %0b", overflow, want.mark));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n > cycle_limit) begin
      $display("timeout after %0d cycles, %0d words due", cycle_n, ways_due_q.size());
      $display("coin_change_way_counter_core_tb: errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < COIN_REGS; i++) coin_reg[i] = COIN_RESET[i];
    kinds_reg = KINDS_RESET;

    // directed: reset coins, bit extremes of the amount
    cur_gap = 37;
    queue_amount(0);
    queue_amount(1);
    queue_amount(5);
    queue_amount(11);
    queue_amount(50);
    queue_amount(100);
    queue_amount(4095);
    // no kinds in use
    queue_reg(REG_KINDS_IN_USE, 0);
    queue_amount(0);
    queue_amount(9);
    // kind counts past the coin registers clamp to five
    queue_reg(REG_KINDS_IN_USE, 7);
    queue_amount(60);
    queue_reg(REG_KINDS_IN_USE, 6);
    queue_amount(33);
    // zero coin value skipped
    queue_reg(REG_KINDS_IN_USE, 5);
    queue_reg(REG_COIN_THREE, 0);
    queue_amount(45);
    // largest coin, above the amount and equal to it
    queue_reg(REG_COIN_ONE, 4095);
    queue_reg(REG_COIN_TWO, 2);
    queue_amount(30);
    queue_amount(4095);
    // writes past the last register are ignored
    queue_reg(REG_SPARE_LO, 4095);
    queue_reg(REG_SPARE_HI, 4095);
    queue_amount(77);
    // single kind of value one
    queue_reg(REG_COIN_ONE, 1);
    queue_reg(REG_KINDS_IN_USE, 1);
    queue_amount(2000);
    queue_reg(REG_COIN_ONE, 7);
    queue_reg(REG_COIN_TWO, 3);
    queue_reg(REG_COIN_FOUR, 4095);
    queue_reg(REG_COIN_FIVE, 1);
    queue_reg(REG_KINDS_IN_USE, 2);
    queue_amount(20);

    // random: sender gaps of 37, then 46, then none
    random_phase(37, 34);
    random_phase(46, 33);
    random_phase(0, 33);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (job_q.size() > 0 || start || ways_due_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d way counts over %0d register writes, %0d amounts above 511",
             words_seen, regs_written, big_amounts);
    if (fail_n == 0) begin
      $display("coin_change_way_counter_core_tb: clean");
    end else begin
      $display("%0d mismatches", fail_n);
      $display("coin_change_way_counter_core_tb: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
src/ccw_pkg.sv
src/ccw_ram.sv
src/ccw_sat_add.sv
src/coin_change_way_counter_core.sv
tb/sv/coin_change_way_counter_core_tb.sv
